>>> hdl/min_coin_change_dp_assert.svh
// assertion macros used by the checker file
`ifndef MIN_COIN_CHANGE_DP_ASSERT_SVH
`define MIN_COIN_CHANGE_DP_ASSERT_SVH

// same-cycle implication
`define MCCD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/mccd_pkg.sv
`timescale 1ns / 1ps

package mccd_pkg;

   // field widths
   localparam int VW = 13;
   localparam int TW = 14;

   // largest value of a 13-bit field
   localparam int VMAX = (2 ** VW) - 1;

   // table marker for an unreached distance
   localparam logic [TW-1:0] INF = {TW{1'b1}};

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_SOLVE = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_LFETCH,
      ST_LCHECK,
      ST_RELAX,
      ST_DRAIN,
      ST_RDREQ,
      ST_RDWAIT,
      ST_HOLD
   } eng_state_type;

   typedef struct packed {
      logic          start;
      logic          take;
      logic [VW-1:0] target;
   } eng_cmd_type;

   typedef struct packed {
      logic          busy;
      logic          result_valid;
      logic          reachable;
      logic [VW-1:0] min_count;
   } eng_sts_type;

endpackage

>>> hdl/mccd_ram.sv
`timescale 1ns / 1ps

module mccd_ram #(
   parameter int WIDTH    = 14,
   parameter int DEPTH    = 8192,
   parameter int RD_PORTS = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [RD_PORTS-1:0][((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [RD_PORTS-1:0][WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-cycle write
   for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
      always_ff @(posedge clock) begin
         rd_data[p] <= mem[rd_addr[p]];
      end
   end

endmodule

>>> hdl/mccd_engine.sv
`timescale 1ns / 1ps

module mccd_engine #(
   parameter int MAX_CLUBS = 32,
   parameter int MAX_DIST  = 8191
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mccd_pkg::eng_cmd_type                       cmd,
   output mccd_pkg::eng_sts_type                       sts,
   input  logic [$clog2(MAX_CLUBS + 1)-1:0]            len_count,
   output logic [((MAX_CLUBS > 1) ? $clog2(MAX_CLUBS) : 1)-1:0] len_rd_addr,
   input  logic [mccd_pkg::VW-1:0]                     len_rd_data
);

   localparam int CW     = $clog2(MAX_CLUBS + 1);
   localparam int IW     = (MAX_CLUBS > 1) ? $clog2(MAX_CLUBS) : 1;
   localparam int TLIM   = (MAX_DIST < mccd_pkg::VMAX) ? MAX_DIST : mccd_pkg::VMAX;
   localparam int TDEPTH = TLIM + 1;
   localparam int AW     = $clog2(TDEPTH);
   localparam int VW     = mccd_pkg::VW;
   localparam int TW     = mccd_pkg::TW;

   mccd_pkg::eng_state_type state_ff, state_in;

   logic [AW-1:0] target_ff, target_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          s1_vld_ff, s1_vld_in;
   logic [AW-1:0] s1_a_ff, s1_a_in;
   logic [AW-1:0] s1_j_ff, s1_j_in;
   logic          fw_vld_ff, fw_vld_in;
   logic [AW-1:0] fw_addr_ff, fw_addr_in;
   logic [TW-1:0] fw_data_ff, fw_data_in;
   logic          res_reach_ff, res_reach_in;
   logic [VW-1:0] res_count_ff, res_count_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [TW-1:0]          wr_data;
   logic [1:0][AW-1:0]     rd_addr;
   logic [1:0][TW-1:0]     rd_data;
   logic [TW-1:0]          va;
   logic [TW-1:0]          cand;

   mccd_ram #(
      .WIDTH   (TW),
      .DEPTH   (TDEPTH),
      .RD_PORTS(2)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mccd_pkg::ST_IDLE;
         s1_vld_ff <= 1'b0;
         fw_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= s1_vld_in;
         fw_vld_ff <= fw_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      j_ff         <= j_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      s1_a_ff      <= s1_a_in;
      s1_j_ff      <= s1_j_in;
      fw_addr_ff   <= fw_addr_in;
      fw_data_ff   <= fw_data_in;
      res_reach_ff <= res_reach_in;
      res_count_ff <= res_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      s1_vld_in    = 1'b0;
      s1_a_in      = s1_a_ff;
      s1_j_in      = s1_j_ff;
      res_reach_in = res_reach_ff;
      res_count_in = res_count_ff;
      rd_addr      = '0;
      len_rd_addr  = idx_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = s1_j_ff;
      wr_data      = '0;

      // write-back of the relax stage, last write forwarded to the a read
      va   = (fw_vld_ff && (fw_addr_ff == s1_a_ff)) ? fw_data_ff : rd_data[0];
      cand = va + TW'(1);
      if (s1_vld_ff && (va != mccd_pkg::INF) && (cand < rd_data[1])) begin
         wr_en   = 1'b1;
         wr_addr = s1_j_ff;
         wr_data = cand;
      end

      case (state_ff)
         mccd_pkg::ST_IDLE: begin
            if (cmd.start) begin
               if (int'(cmd.target) > MAX_DIST) begin
                  res_reach_in = 1'b0;
                  res_count_in = '0;
                  state_in     = mccd_pkg::ST_HOLD;
               end else begin
                  target_in = cmd.target[AW-1:0];
                  j_in      = '0;
                  state_in  = mccd_pkg::ST_INIT;
               end
            end
         end
         mccd_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = (j_ff == '0) ? '0 : mccd_pkg::INF;
            if (j_ff == target_ff) begin
               idx_in   = '0;
               state_in = mccd_pkg::ST_LFETCH;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         mccd_pkg::ST_LFETCH: begin
            if (idx_ff == len_count) begin
               state_in = mccd_pkg::ST_RDREQ;
            end else begin
               state_in = mccd_pkg::ST_LCHECK;
            end
         end
         mccd_pkg::ST_LCHECK: begin
            idx_in = idx_ff + CW'(1);
            if ((len_rd_data == '0) || (len_rd_data > VW'(target_ff))) begin
               state_in = mccd_pkg::ST_LFETCH;
            end else begin
               len_in   = len_rd_data[AW-1:0];
               j_in     = len_rd_data[AW-1:0];
               state_in = mccd_pkg::ST_RELAX;
            end
         end
         mccd_pkg::ST_RELAX: begin
            rd_addr[0] = j_ff - len_ff;
            rd_addr[1] = j_ff;
            s1_vld_in  = 1'b1;
            s1_a_in    = j_ff - len_ff;
            s1_j_in    = j_ff;
            if (j_ff == target_ff) begin
               state_in = mccd_pkg::ST_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         mccd_pkg::ST_DRAIN: begin
            state_in = mccd_pkg::ST_LFETCH;
         end
         mccd_pkg::ST_RDREQ: begin
            rd_addr[1] = target_ff;
            state_in   = mccd_pkg::ST_RDWAIT;
         end
         mccd_pkg::ST_RDWAIT: begin
            res_reach_in = (rd_data[1] != mccd_pkg::INF);
            res_count_in = (rd_data[1] != mccd_pkg::INF) ? rd_data[1][VW-1:0] : '0;
            state_in     = mccd_pkg::ST_HOLD;
         end
         mccd_pkg::ST_HOLD: begin
            if (cmd.take) begin
               state_in = mccd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mccd_pkg::ST_IDLE;
         end
      endcase

      fw_vld_in  = wr_en;
      fw_addr_in = wr_addr;
      fw_data_in = wr_data;
   end

   always_comb begin
      sts.busy         = (state_ff != mccd_pkg::ST_IDLE);
      sts.result_valid = (state_ff == mccd_pkg::ST_HOLD);
      sts.reachable    = res_reach_ff;
      sts.min_count    = res_count_ff;
   end

endmodule

>>> hdl/min_coin_change_dp.sv
`timescale 1ns / 1ps
// minimum-count unbounded coin change over a stored list of step lengths
// req channel (req_valid / req_stall): req_action selects add, solve or clear,
//   req_value carries the step length (add) or the target distance (solve)
// add and clear give no rsp beat; a zero length or an add
//   to a full list is dropped
// solve gives one rsp beat: rsp_reachable and rsp_min_count (0 if unreachable)
// solve, for target t <= MAX_DIST: the table is set for 0..t, one relax pass
//   runs per stored length in 1..t (others are skipped) and entry t is read;
//   a target beyond MAX_DIST is answered unreachable without a table pass
// the relax pass does one table update per cycle on the best-table memory
//   (two read ports, one write port, last write forwarded to the next read)
// req_stall is high while a solve runs and until its result moves into the
//   output register, so one item is worked at a time
// add and clear are still taken while a result waits in the output register
//   behind rsp_stall, but not in the engine; rsp payload holds while stalled
// reset (synchronous) empties the length list and the output register; the
//   memories need no clearing pass
module min_coin_change_dp #(
   parameter int MAX_CLUBS = 32,
   parameter int MAX_DIST  = 8191
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic [mccd_pkg::VW-1:0] req_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_reachable,
   output logic [mccd_pkg::VW-1:0] rsp_min_count
);

   localparam int CW = $clog2(MAX_CLUBS + 1);
   localparam int IW = (MAX_CLUBS > 1) ? $clog2(MAX_CLUBS) : 1;
   localparam int VW = mccd_pkg::VW;

   // length list fill count
   logic [CW-1:0] count_ff, count_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_reach_ff, rsp_reach_in;
   logic [VW-1:0] rsp_count_ff, rsp_count_in;

   logic                  req_beat;
   logic                  len_wr_en;
   logic [IW-1:0]         len_rd_addr;
   logic [0:0][VW-1:0]    len_rd_data;
   mccd_pkg::eng_cmd_type cmd;
   mccd_pkg::eng_sts_type sts;

   assign req_beat = req_valid && !req_stall;
   assign req_stall = sts.busy;

   // add stores at the fill position while there is room
   assign len_wr_en = req_beat && (req_action == mccd_pkg::ACT_ADD) &&
                      (req_value != '0) && (count_ff < CW'(MAX_CLUBS));

   mccd_ram #(
      .WIDTH   (VW),
      .DEPTH   (MAX_CLUBS),
      .RD_PORTS(1)
   ) u_lengths (
      .clock  (clock),
      .wr_en  (len_wr_en),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(req_value),
      .rd_addr(len_rd_addr),
      .rd_data(len_rd_data)
   );

   mccd_engine #(
      .MAX_CLUBS(MAX_CLUBS),
      .MAX_DIST (MAX_DIST)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .len_count  (count_ff),
      .len_rd_addr(len_rd_addr),
      .len_rd_data(len_rd_data[0])
   );

   always_comb begin
      cmd.start  = req_beat && (req_action == mccd_pkg::ACT_SOLVE);
      cmd.target = req_value;
      // result moves out when the output register is empty or being drained
      cmd.take   = sts.result_valid && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      count_in = count_ff;
      if (req_beat && (req_action == mccd_pkg::ACT_CLEAR)) begin
         count_in = '0;
      end else if (len_wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_reach_in = rsp_reach_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.take) begin
         rsp_valid_in = 1'b1;
         rsp_reach_in = sts.reachable;
         rsp_count_in = sts.min_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reach_ff <= rsp_reach_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_min_count = rsp_count_ff;

endmodule

>>> hdl/mccd_checker.sv
`timescale 1ns / 1ps
`include "min_coin_change_dp_assert.svh"

module mccd_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [1:0]              req_action,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_reachable,
   input logic [mccd_pkg::VW-1:0] rsp_min_count
);

   `MCCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped while stalled")

   `MCCD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_reachable) && $stable(rsp_min_count), "rsp payload changed while stalled")

   `MCCD_ASSERT_NOW(a_unreach_zero, clock, reset, rsp_valid && !rsp_reachable, rsp_min_count == '0, "unreachable result with nonzero count")

   `MCCD_ASSERT_NEXT(a_solve_busy, clock, reset, req_valid && !req_stall && (req_action == mccd_pkg::ACT_SOLVE), req_stall, "solve accepted but block not busy")

endmodule

bind min_coin_change_dp mccd_checker u_checker (.*);
